// ===== src/sapq_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and command/status types for the sorted array priority queue
// no dependencies

package sapq_pkg;

    localparam int VALUE_W       = 32;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 2;
    localparam int OCC_W         = 5;
    localparam int DEFAULT_DEPTH = 16;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic latch;
        logic rd_head;
        logic rd_pos;
        logic shift;
        logic put;
        logic fetch;
        logic set_full;
        logic set_empty;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             full;
        logic             empty;
        logic             pos_zero;
        logic             pos_one;
        logic             gt;
        logic             out_free;
    } t_sts;

endpackage

// ===== src/sapq_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the sorted array priority queue
// depends on sapq_pkg

module sapq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  sapq_pkg::t_sts i_sts,
    output sapq_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_FETCH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.act)
                    sapq_pkg::ACT_ENQ: begin
                        if (i_sts.full) begin
                            o_cmd.set_full = 1'b1;
                            n_state        = S_DONE;
                        end else if (i_sts.pos_zero) begin
                            n_state = S_INS_PUT;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    sapq_pkg::ACT_DEQ, sapq_pkg::ACT_PEEK: begin
                        if (i_sts.empty) begin
                            o_cmd.set_empty = 1'b1;
                            n_state         = S_DONE;
                        end else begin
                            o_cmd.rd_head = 1'b1;
                            n_state       = S_FETCH;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS_RD: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.pos_one ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sapq_dp.sv =====
`timescale 1ns / 1ps
// datapath for the sorted array priority queue: circular entry memory, head,
// count, insert position and output register; depends on sapq_pkg

module sapq_dp #(
    parameter int DEPTH = sapq_pkg::DEFAULT_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [sapq_pkg::ACT_W-1:0]          i_act,
    input  logic signed [sapq_pkg::VALUE_W-1:0] i_value,
    input  sapq_pkg::t_cmd                      i_cmd,
    output sapq_pkg::t_sts                      o_sts,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic signed [sapq_pkg::VALUE_W-1:0] o_result_value,
    output logic [sapq_pkg::STAT_W-1:0]         o_status,
    output logic [sapq_pkg::OCC_W-1:0]          o_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic signed [sapq_pkg::VALUE_W-1:0] r_mem [DEPTH];

    logic [AW-1:0]                       r_head;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       r_pos;
    logic [sapq_pkg::ACT_W-1:0]          r_act;
    logic signed [sapq_pkg::VALUE_W-1:0] r_val;
    logic signed [sapq_pkg::VALUE_W-1:0] r_rd;
    logic signed [sapq_pkg::VALUE_W-1:0] r_res;
    logic [sapq_pkg::STAT_W-1:0]         r_st;

    logic                                r_o_valid;
    logic signed [sapq_pkg::VALUE_W-1:0] r_o_res;
    logic [sapq_pkg::STAT_W-1:0]         r_o_st;
    logic [CW-1:0]                       r_o_cnt;

    logic [CW-1:0] pos_m1;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          out_free;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign pos_m1   = r_pos - CW'(1);
    assign wr_addr  = phys(r_head, r_pos[AW-1:0]);
    assign rd_addr  = i_cmd.rd_head ? r_head : phys(r_head, pos_m1[AW-1:0]);
    assign out_free = !r_o_valid || i_m_tready;

    always_comb begin
        o_sts.act      = r_act;
        o_sts.full     = (r_count == DEPTH_C);
        o_sts.empty    = (r_count == '0);
        o_sts.pos_zero = (r_pos == '0);
        o_sts.pos_one  = (r_pos == CW'(1));
        o_sts.gt       = (r_rd > r_val);
        o_sts.out_free = out_free;
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_mem[wr_addr] <= r_rd;
        end else if (i_cmd.put) begin
            r_mem[wr_addr] <= r_val;
        end
        if (i_cmd.rd_head || i_cmd.rd_pos) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act <= i_act;
            r_val <= i_value;
            r_res <= '0;
            r_st  <= sapq_pkg::ST_OK;
        end else begin
            if (i_cmd.set_full) begin
                r_st <= sapq_pkg::ST_FULL;
            end
            if (i_cmd.set_empty) begin
                r_st <= sapq_pkg::ST_EMPTY;
            end
            if (i_cmd.fetch) begin
                r_res <= r_rd;
            end
        end
    end

    // queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_pos <= r_count;
            end else if (i_cmd.shift) begin
                r_pos <= pos_m1;
            end
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.fetch && (r_act == sapq_pkg::ACT_DEQ)) begin
                r_count <= r_count - CW'(1);
                r_head  <= (r_head == LAST_A) ? '0 : r_head + AW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_res <= r_res;
            r_o_st  <= r_st;
            r_o_cnt <= r_count;
        end
    end

    assign o_m_tvalid     = r_o_valid;
    assign o_result_value = r_o_res;
    assign o_status       = r_o_st;

    generate
        if (CW >= sapq_pkg::OCC_W) begin : g_occ_trunc
            assign o_occupancy = r_o_cnt[sapq_pkg::OCC_W-1:0];
        end else begin : g_occ_ext
            assign o_occupancy = {(sapq_pkg::OCC_W - CW)'(0), r_o_cnt};
        end
    endgenerate

endmodule

// ===== src/sorted_array_priority_queue.sv =====
`timescale 1ns / 1ps
// top level of the sorted array min-priority queue; depends on sapq_pkg,
// sapq_ctrl and sapq_dp
// one request at a time; peek and dequeue read the head entry, full and empty replies
// go straight to the output, and an enqueue moves each larger entry up one place before
// it writes the value; input ready returns with output valid, both later if output is held
// reset clears head, count and output valid; the entry memory is not cleared

module sorted_array_priority_queue #(
    parameter int DEPTH = sapq_pkg::DEFAULT_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // action [1:0], value [33:2], zero [39:34]
    input  logic [sapq_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // result_value [31:0], status [33:32], occupancy [38:34], zero [39]
    output logic [sapq_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    sapq_pkg::t_cmd cmd;
    sapq_pkg::t_sts sts;

    logic signed [sapq_pkg::VALUE_W-1:0] result_value;
    logic [sapq_pkg::STAT_W-1:0]         status;
    logic [sapq_pkg::OCC_W-1:0]          occupancy;

    sapq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sapq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_act          (i_s_tdata[sapq_pkg::ACT_W-1:0]),
        .i_value        (i_s_tdata[sapq_pkg::ACT_W +: sapq_pkg::VALUE_W]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_result_value (result_value),
        .o_status       (status),
        .o_occupancy    (occupancy)
    );

    assign o_m_tdata = {1'b0, occupancy, status, result_value};

endmodule
